@@ rtl/pws_pkg.sv @@
// Shared constants, types and small functions of the polyphonic wavetable synthesizer.
// No dependencies; every other file of the block imports this package.
package pws_pkg;

    localparam int TableLen  = 48000;
    localparam int Voices    = 8;
    localparam int SineWidth = 24;

    localparam logic [15:0] TABLE_LEN16 = 16'(TableLen);
    localparam logic [15:0] QTR1        = 16'(TableLen / 4);
    localparam logic [15:0] QTR2        = 16'(TableLen / 2);
    localparam logic [15:0] QTR3        = 16'((3 * TableLen) / 4);
    localparam logic [15:0] SAMPLE_WRAP = 16'd48000;

    localparam logic [30:0] HALFPI_Q30     = 31'd1686629713;
    localparam logic [22:0] SINE_AMP       = 23'((1 << (SineWidth - 1)) - 1);
    localparam logic [63:0] ROUND_HALF_Q30 = 64'h0000_0000_2000_0000;

    localparam logic [4:0] GAIN_MAX   = 5'd20;
    localparam logic [4:0] GAIN_RESET = 5'd2;

    localparam logic [7:0] CODE_RELEASE  = 8'hF0;
    localparam logic [7:0] CODE_VOL_DOWN = 8'h41;
    localparam logic [7:0] CODE_VOL_UP   = 8'h49;

    localparam logic [7:0] NOTE_CODES [8] = '{
        8'h1C, 8'h1B, 8'h23, 8'h2B, 8'h3B, 8'h42, 8'h4B, 8'h4C
    };

    localparam logic [24:0] FREQ_RESET [8] = '{
        25'd8572961, 25'd9622782, 25'd10801250, 25'd11443503,
        25'd12844925, 25'd14417920, 25'd16183591, 25'd17145922
    };

    // Serial unit lengths: one multiplier bit or one quotient bit per cycle.
    localparam logic [5:0] MUL_STEPS = 6'd32;
    localparam logic [5:0] DIV_STEPS = 6'd48;

    typedef struct packed {
        logic        start;
        logic [47:0] a;
        logic [31:0] b;
    } mul_req_t;

    typedef struct packed {
        logic        start;
        logic [47:0] dividend;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic [7:0] keys;
        logic [4:0] gain;
    } keys_t;

    typedef struct packed {
        logic signed [30:0] sample;
        logic [7:0]         keys;
        logic [4:0]         gain;
    } result_t;

    // Divisor (2n)(2n+1) of the n-th Taylor term of the sine series.
    function automatic logic [15:0] taylor_div(input logic [2:0] n);
        logic [15:0] d;
        case (n)
            3'd1: d = 16'd6;
            3'd2: d = 16'd20;
            3'd3: d = 16'd42;
            3'd4: d = 16'd72;
            3'd5: d = 16'd110;
            3'd6: d = 16'd156;
            3'd7: d = 16'd210;
            default: d = 16'd1;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/pws_mul.sv @@
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on pws_pkg for the request type and the step count.
module pws_mul (
    input  logic              aclk,
    input  logic              aresetn,
    input  pws_pkg::mul_req_t req,
    output logic              done,
    output logic [63:0]       prod
);
    import pws_pkg::*;

    logic [63:0] acc_reg, acc_next;
    logic [63:0] a_reg, a_next;
    logic [31:0] b_reg, b_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    always_comb begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start) begin
            acc_next  = '0;
            a_next    = {16'b0, req.a};
            b_next    = req.b;
            cnt_next  = MUL_STEPS;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (b_reg[0]) begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = {a_reg[62:0], 1'b0};
            b_next   = {1'b0, b_reg[31:1]};
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

@@ rtl/pws_div.sv @@
// Restoring bit-serial divider, one quotient bit per cycle.
// Depends on pws_pkg for the request type and the step count.
module pws_div (
    input  logic              aclk,
    input  logic              aresetn,
    input  pws_pkg::div_req_t req,
    output logic              done,
    output logic [47:0]       quo,
    output logic [15:0]       rem
);
    import pws_pkg::*;

    logic [47:0] quo_reg, quo_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] trial;

    always_comb begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg, quo_reg[47]};
        if (req.start) begin
            quo_next  = req.dividend;
            rem_next  = '0;
            dvs_next  = req.divisor;
            cnt_next  = DIV_STEPS;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            if (trial >= {1'b0, dvs_reg}) begin
                rem_next = 16'(trial - {1'b0, dvs_reg});
                quo_next = {quo_reg[46:0], 1'b1};
            end else begin
                rem_next = trial[15:0];
                quo_next = {quo_reg[46:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

@@ rtl/pws_keys.sv @@
// Scan code decoder: note bits, release mark and volume in half steps.
// Depends on pws_pkg for the code constants and the state type.
module pws_keys (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           code_valid,
    input  logic [7:0]     code,
    output pws_pkg::keys_t state
);
    import pws_pkg::*;

    logic [7:0] key_reg, key_next;
    logic       rel_reg, rel_next;
    logic [4:0] gain_reg, gain_next;
    logic       hit;

    always_comb begin
        key_next  = key_reg;
        rel_next  = rel_reg;
        gain_next = gain_reg;
        hit       = 1'b0;
        if (code_valid) begin
            for (int v = 0; v < Voices; v++) begin
                if (!hit && code == NOTE_CODES[v]) begin
                    hit = 1'b1;
                    if (rel_reg) begin
                        key_next[v] = 1'b0;
                        rel_next    = 1'b0;
                    end else begin
                        key_next[v] = 1'b1;
                    end
                end
            end
            if (!hit) begin
                case (code)
                    CODE_VOL_DOWN: begin
                        if (gain_reg != 5'd0) begin
                            gain_next = gain_reg - 5'd1;
                        end
                        rel_next = 1'b0;
                    end
                    CODE_VOL_UP: begin
                        if (gain_reg < GAIN_MAX) begin
                            gain_next = gain_reg + 5'd1;
                        end
                        rel_next = 1'b0;
                    end
                    CODE_RELEASE: rel_next = 1'b1;
                    default:      rel_next = 1'b0;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg  <= '0;
            rel_reg  <= 1'b0;
            gain_reg <= GAIN_RESET;
        end else begin
            key_reg  <= key_next;
            rel_reg  <= rel_next;
            gain_reg <= gain_next;
        end
    end

    assign state.keys = key_reg;
    assign state.gain = gain_reg;

endmodule

@@ rtl/pws_seq.sv @@
// Tick sequencer: per held voice phase, table index, two series sine values and the
// interpolated, gain-scaled sum. Depends on pws_pkg, pws_mul and pws_div.
module pws_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             tick_start,
    input  pws_pkg::keys_t   keys,
    input  logic             cfg_wen,
    input  logic [2:0]       cfg_index,
    input  logic [24:0]      cfg_wdata,
    input  logic             out_free,
    output logic             busy,
    output logic             result_valid,
    output pws_pkg::result_t result
);
    import pws_pkg::*;

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_VCHECK = 4'd1;
    localparam logic [3:0] ST_PHASE  = 4'd2;
    localparam logic [3:0] ST_IDX    = 4'd3;
    localparam logic [3:0] ST_SSTART = 4'd4;
    localparam logic [3:0] ST_X0     = 4'd5;
    localparam logic [3:0] ST_X1     = 4'd6;
    localparam logic [3:0] ST_X2     = 4'd7;
    localparam logic [3:0] ST_T0     = 4'd8;
    localparam logic [3:0] ST_T1     = 4'd9;
    localparam logic [3:0] ST_AMP    = 4'd10;
    localparam logic [3:0] ST_VM0    = 4'd11;
    localparam logic [3:0] ST_VM1    = 4'd12;
    localparam logic [3:0] ST_VNEXT  = 4'd13;
    localparam logic [3:0] ST_FIN    = 4'd14;
    localparam logic [3:0] ST_HOLD   = 4'd15;

    localparam logic [2:0] LAST_VOICE = 3'(Voices - 1);
    localparam logic [2:0] LAST_TERM  = 3'd7;

    logic [3:0]         state_reg, state_next;
    logic [24:0]        freq_reg [8];
    logic [15:0]        t_reg, t_next;
    logic [2:0]         v_reg, v_next;
    logic signed [43:0] sum_reg, sum_next;
    logic [15:0]        frac_reg, frac_next;
    logic [15:0]        nxt_reg, nxt_next;
    logic [15:0]        k_reg, k_next;
    logic               sel_reg, sel_next;
    logic [1:0]         quad_reg, quad_next;
    logic [31:0]        x2_reg, x2_next;
    logic [31:0]        term_reg, term_next;
    logic signed [33:0] ssum_reg, ssum_next;
    logic [2:0]         n_reg, n_next;
    logic [22:0]        s0mag_reg, s0mag_next;
    logic               s0neg_reg, s0neg_next;
    logic [22:0]        s1mag_reg, s1mag_next;
    logic               s1neg_reg, s1neg_next;
    logic [30:0]        res_reg, res_next;
    mul_req_t           mreq_reg, mreq_next;
    div_req_t           dreq_reg, dreq_next;

    logic               mul_done, div_done;
    logic [63:0]        mul_prod;
    logic [47:0]        div_quo;
    logic [15:0]        div_rem;

    logic [1:0]         quad;
    logic [15:0]        qbase;
    logic [15:0]        rq;
    logic [15:0]        kk;
    logic signed [33:0] ssum_upd;
    logic [32:0]        ssum_pos;
    logic [63:0]        rnd;
    logic [22:0]        smag;
    logic [43:0]        sum_abs;
    logic signed [43:0] vprod;
    logic [30:0]        mag;

    pws_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (mreq_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    pws_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq_reg),
        .done    (div_done),
        .quo     (div_quo),
        .rem     (div_rem)
    );

    // Fold the table index into the first quarter of the period.
    always_comb begin
        if (k_reg < QTR1) begin
            quad  = 2'd0;
            qbase = 16'd0;
        end else if (k_reg < QTR2) begin
            quad  = 2'd1;
            qbase = QTR1;
        end else if (k_reg < QTR3) begin
            quad  = 2'd2;
            qbase = QTR2;
        end else begin
            quad  = 2'd3;
            qbase = QTR3;
        end
        rq = 16'((k_reg - qbase) << 2);
        kk = quad[0] ? 16'(TABLE_LEN16 - rq) : rq;
    end

    always_comb begin
        ssum_upd = n_reg[0] ? ssum_reg - $signed({2'b00, div_quo[31:0]})
                            : ssum_reg + $signed({2'b00, div_quo[31:0]});
        ssum_pos = ssum_upd[33] ? 33'd0 : ssum_upd[32:0];
        rnd      = mul_prod + ROUND_HALF_Q30;
        smag     = (rnd[63:30] > 34'(SINE_AMP)) ? SINE_AMP : rnd[52:30];
        sum_abs  = sum_reg[43] ? 44'(-sum_reg) : 44'(sum_reg);
        vprod    = $signed({1'b0, mul_prod[42:0]});
        mag      = mul_prod[47:17];
    end

    always_comb begin
        state_next      = state_reg;
        t_next          = t_reg;
        v_next          = v_reg;
        sum_next        = sum_reg;
        frac_next       = frac_reg;
        nxt_next        = nxt_reg;
        k_next          = k_reg;
        sel_next        = sel_reg;
        quad_next       = quad_reg;
        x2_next         = x2_reg;
        term_next       = term_reg;
        ssum_next       = ssum_reg;
        n_next          = n_reg;
        s0mag_next      = s0mag_reg;
        s0neg_next      = s0neg_reg;
        s1mag_next      = s1mag_reg;
        s1neg_next      = s1neg_reg;
        res_next        = res_reg;
        mreq_next       = mreq_reg;
        mreq_next.start = 1'b0;
        dreq_next       = dreq_reg;
        dreq_next.start = 1'b0;
        result_valid    = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (tick_start) begin
                    v_next     = '0;
                    sum_next   = '0;
                    state_next = ST_VCHECK;
                end
            end
            ST_VCHECK: begin
                if (keys.keys[v_reg]) begin
                    mreq_next  = '{start: 1'b1, a: 48'(freq_reg[v_reg]), b: 32'(t_reg)};
                    state_next = ST_PHASE;
                end else begin
                    state_next = ST_VNEXT;
                end
            end
            ST_PHASE: begin
                if (mul_done) begin
                    frac_next  = mul_prod[15:0];
                    dreq_next  = '{start: 1'b1, dividend: 48'(mul_prod[40:16]),
                                   divisor: TABLE_LEN16};
                    state_next = ST_IDX;
                end
            end
            ST_IDX: begin
                if (div_done) begin
                    k_next     = div_rem;
                    nxt_next   = (div_rem == TABLE_LEN16 - 16'd1) ? 16'd0
                                                                  : div_rem + 16'd1;
                    sel_next   = 1'b0;
                    state_next = ST_SSTART;
                end
            end
            ST_SSTART: begin
                quad_next  = quad;
                mreq_next  = '{start: 1'b1, a: 48'(HALFPI_Q30), b: 32'(kk)};
                state_next = ST_X0;
            end
            ST_X0: begin
                if (mul_done) begin
                    dreq_next  = '{start: 1'b1, dividend: mul_prod[47:0],
                                   divisor: TABLE_LEN16};
                    state_next = ST_X1;
                end
            end
            ST_X1: begin
                if (div_done) begin
                    term_next  = 32'(div_quo[30:0]);
                    ssum_next  = $signed(34'(div_quo[30:0]));
                    mreq_next  = '{start: 1'b1, a: 48'(div_quo[30:0]),
                                   b: 32'(div_quo[30:0])};
                    state_next = ST_X2;
                end
            end
            ST_X2: begin
                if (mul_done) begin
                    x2_next    = mul_prod[61:30];
                    n_next     = 3'd1;
                    mreq_next  = '{start: 1'b1, a: 48'(term_reg), b: mul_prod[61:30]};
                    state_next = ST_T0;
                end
            end
            ST_T0: begin
                if (mul_done) begin
                    dreq_next  = '{start: 1'b1, dividend: 48'(mul_prod[63:30]),
                                   divisor: taylor_div(n_reg)};
                    state_next = ST_T1;
                end
            end
            ST_T1: begin
                if (div_done) begin
                    term_next = div_quo[31:0];
                    ssum_next = ssum_upd;
                    if (n_reg == LAST_TERM) begin
                        mreq_next  = '{start: 1'b1, a: 48'(ssum_pos), b: 32'(SINE_AMP)};
                        state_next = ST_AMP;
                    end else begin
                        n_next     = n_reg + 3'd1;
                        mreq_next  = '{start: 1'b1, a: 48'(div_quo[31:0]), b: x2_reg};
                        state_next = ST_T0;
                    end
                end
            end
            ST_AMP: begin
                if (mul_done) begin
                    if (!sel_reg) begin
                        s0mag_next = smag;
                        s0neg_next = quad_reg[1];
                        k_next     = nxt_reg;
                        sel_next   = 1'b1;
                        state_next = ST_SSTART;
                    end else begin
                        s1mag_next = smag;
                        s1neg_next = quad_reg[1];
                        mreq_next  = '{start: 1'b1, a: 48'(s0mag_reg),
                                       b: 32'(17'h10000 - {1'b0, frac_reg})};
                        state_next = ST_VM0;
                    end
                end
            end
            ST_VM0: begin
                if (mul_done) begin
                    sum_next   = s0neg_reg ? sum_reg - vprod : sum_reg + vprod;
                    mreq_next  = '{start: 1'b1, a: 48'(s1mag_reg), b: 32'(frac_reg)};
                    state_next = ST_VM1;
                end
            end
            ST_VM1: begin
                if (mul_done) begin
                    sum_next   = s1neg_reg ? sum_reg - vprod : sum_reg + vprod;
                    state_next = ST_VNEXT;
                end
            end
            ST_VNEXT: begin
                if (v_reg == LAST_VOICE) begin
                    mreq_next  = '{start: 1'b1, a: 48'(sum_abs), b: 32'(keys.gain)};
                    state_next = ST_FIN;
                end else begin
                    v_next     = v_reg + 3'd1;
                    state_next = ST_VCHECK;
                end
            end
            ST_FIN: begin
                if (mul_done) begin
                    res_next   = sum_reg[43] ? 31'd0 - mag : mag;
                    t_next     = (t_reg == SAMPLE_WRAP) ? 16'd0 : t_reg + 16'd1;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD: begin
                // The result waits here until the output register can take it.
                if (out_free) begin
                    result_valid = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            t_reg          <= '0;
            mreq_reg.start <= 1'b0;
            dreq_reg.start <= 1'b0;
            for (int i = 0; i < 8; i++) begin
                freq_reg[i] <= FREQ_RESET[i];
            end
        end else begin
            state_reg      <= state_next;
            t_reg          <= t_next;
            mreq_reg.start <= mreq_next.start;
            dreq_reg.start <= dreq_next.start;
            if (cfg_wen) begin
                freq_reg[cfg_index] <= cfg_wdata;
            end
        end
        mreq_reg.a        <= mreq_next.a;
        mreq_reg.b        <= mreq_next.b;
        dreq_reg.dividend <= dreq_next.dividend;
        dreq_reg.divisor  <= dreq_next.divisor;
        v_reg     <= v_next;
        sum_reg   <= sum_next;
        frac_reg  <= frac_next;
        nxt_reg   <= nxt_next;
        k_reg     <= k_next;
        sel_reg   <= sel_next;
        quad_reg  <= quad_next;
        x2_reg    <= x2_next;
        term_reg  <= term_next;
        ssum_reg  <= ssum_next;
        n_reg     <= n_next;
        s0mag_reg <= s0mag_next;
        s0neg_reg <= s0neg_next;
        s1mag_reg <= s1mag_next;
        s1neg_reg <= s1neg_next;
        res_reg   <= res_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result.sample = $signed(res_reg);
    assign result.keys   = keys.keys;
    assign result.gain   = keys.gain;

endmodule

@@ rtl/polyphonic_wavetable_synth_core.sv @@
// Top level of the eight-voice wavetable synthesizer: handshakes and the result register.
// Depends on pws_pkg, pws_keys and pws_seq.
//
// Usage: the input channel (s_valid/s_ready) carries one request per item: s_op = 0
// delivers a PS/2 scan code in s_scan_code, s_op = 1 is an audio sample tick. Scan codes
// produce no result. Each tick produces one result on the m_ channel: the gain-scaled sum
// of the held voices, the held-key bits and the volume in half steps.
// The shared bit-serial multiplier and the restoring divider evaluate the phase, the table
// index and two series sine values per voice.
// The user must write note frequencies on the cfg_wen/cfg_index/cfg_wdata port only while
// the block is idle; the block itself does not enforce this.
// The sine values are computed on demand; there is no table memory and no fill pass.
// The input is not ready while a tick is being computed.
// Reset (aresetn low, synchronous) restores the default frequencies, clears the keys,
// the release mark and the sample counter, and sets the gain to one.
// When the receiver stalls, the finished result waits in the output register; the block
// keeps taking requests, and a second tick finishes but waits until that register frees.
module polyphonic_wavetable_synth_core (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_op,
    input  logic [7:0]         s_scan_code,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [30:0] m_sample,
    output logic [7:0]         m_keys_down,
    output logic [4:0]         m_volume_halves,
    input  logic               cfg_wen,
    input  logic [2:0]         cfg_index,
    input  logic [24:0]        cfg_wdata
);
    import pws_pkg::*;

    keys_t   keys;
    result_t result;
    logic    seq_busy;
    logic    result_valid;
    logic    accept;
    logic    out_free;

    logic               m_valid_reg, m_valid_next;
    logic signed [30:0] sample_reg;
    logic [7:0]         keys_reg;
    logic [4:0]         gain_reg;

    assign s_ready  = !seq_busy;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    pws_keys u_keys (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .code_valid (accept && !s_op),
        .code       (s_scan_code),
        .state      (keys)
    );

    pws_seq u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .tick_start   (accept && s_op),
        .keys         (keys),
        .cfg_wen      (cfg_wen),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .out_free     (out_free),
        .busy         (seq_busy),
        .result_valid (result_valid),
        .result       (result)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (result_valid) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
        if (result_valid) begin
            sample_reg <= result.sample;
            keys_reg   <= result.keys;
            gain_reg   <= result.gain;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_sample        = sample_reg;
    assign m_keys_down     = keys_reg;
    assign m_volume_halves = gain_reg;

endmodule

@@ test/tb_polyphonic_wavetable_synth_core.sv @@
// Testbench for polyphonic_wavetable_synth_core: a scoreboard class predicts every tick result
// and plain tasks drive scan codes, ticks and frequency writes. Depends on pws_pkg.
module tb_polyphonic_wavetable_synth_core;
    timeunit 1ns;
    timeprecision 1ps;
    import pws_pkg::*;

    localparam logic OP_KEY  = 1'b0;
    localparam logic OP_TICK = 1'b1;
    localparam int   ROM_LEN = 48000;
    localparam logic [24:0] FREQ_MAX = 25'h1FF_FFFF;

    class synth_scoreboard;
        logic [24:0] freq [8];
        logic [7:0]  keys;
        logic        rel_mark;
        logic [4:0]  gain;
        int          t_index;
        int          sine [ROM_LEN];
        result_t     pending_samples [$];
        int          errors;

        function new();
            longint unsigned amp;
            longint unsigned q;
            int s;
            amp = (64'd1 << 23) - 1;
            for (int i = 0; i < ROM_LEN; i++) begin
                q = 4 * i;
                if ((q / ROM_LEN) % 2 == 1) s = quarter(ROM_LEN - q % ROM_LEN, amp);
                else s = quarter(q % ROM_LEN, amp);
                sine[i] = ((q / ROM_LEN) & 2) ? -s : s;
            end
            errors = 0;
            reset_state();
        endfunction

        function int quarter(longint unsigned k, longint unsigned amp);
            longint unsigned x, x2, term, v;
            longint sum;
            x = (64'd1686629713 * k) / ROM_LEN;
            x2 = (x * x) >> 30;
            term = x;
            sum = x;
            for (int n = 1; n <= 7; n++) begin
                term = ((term * x2) >> 30) / ((2 * n) * (2 * n + 1));
                if (n % 2 == 1) sum -= longint'(term);
                else sum += longint'(term);
            end
            if (sum < 0) sum = 0;
            v = (longint'(sum) * amp + (64'd1 << 29)) >> 30;
            if (v > amp) v = amp;
            return int'(v);
        endfunction

        function void reset_state();
            for (int i = 0; i < 8; i++) freq[i] = FREQ_RESET[i];
            keys = '0;
            rel_mark = 1'b0;
            gain = GAIN_RESET;
            t_index = 0;
        endfunction

        function void set_freq(int idx, logic [24:0] value);
            freq[idx] = value;
        endfunction

        function void note_request(logic op, logic [7:0] code);
            longint sum, acc, phase, frac, idx;
            result_t r;
            if (op == OP_KEY) begin
                for (int v = 0; v < 8; v++) begin
                    if (code == NOTE_CODES[v]) begin
                        if (rel_mark) begin
                            keys[v] = 1'b0;
                            rel_mark = 1'b0;
                        end else begin
                            keys[v] = 1'b1;
                        end
                        return;
                    end
                end
                if (code == CODE_VOL_DOWN) begin
                    if (gain > 0) gain--;
                    rel_mark = 1'b0;
                end else if (code == CODE_VOL_UP) begin
                    if (gain < GAIN_MAX) gain++;
                    rel_mark = 1'b0;
                end else begin
                    rel_mark = (code == CODE_RELEASE);
                end
                return;
            end
            sum = 0;
            for (int v = 0; v < 8; v++) begin
                if (keys[v]) begin
                    phase = longint'(freq[v]) * t_index;
                    frac = phase & 64'hFFFF;
                    idx = (phase >> 16) % ROM_LEN;
                    sum += (65536 - frac) * sine[idx] + frac * sine[(idx + 1) % ROM_LEN];
                end
            end
            acc = sum * longint'(gain);
            if (acc >= 0) acc = acc >> 17;
            else acc = -((-acc) >> 17);
            r.sample = acc[30:0];
            r.keys = keys;
            r.gain = gain;
            pending_samples.push_back(r);
            t_index++;
            if (t_index > 48000) t_index = 0;
        endfunction

        function void check_result(logic [30:0] sample, logic [7:0] kd, logic [4:0] vol);
            result_t e;
            if (pending_samples.size() == 0) begin
                $display("%0t: unexpected result sample=%0d keys=%h volume=%0d",
                         $time, $signed(sample), kd, vol);
                errors++;
                return;
            end
            e = pending_samples.pop_front();
            if (e.sample !== sample) begin
                $display("%0t: sample expected %0d actual %0d", $time, e.sample,
                         $signed(sample));
                errors++;
            end
            if (e.keys !== kd) begin
                $display("%0t: keys_down expected %h actual %h", $time, e.keys, kd);
                errors++;
            end
            if (e.gain !== vol) begin
                $display("%0t: volume_halves expected %0d actual %0d", $time, e.gain, vol);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic               s_op = 1'b0;
    logic [7:0]         s_scan_code = '0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic signed [30:0] m_sample;
    logic [7:0]         m_keys_down;
    logic [4:0]         m_volume_halves;
    logic               cfg_wen = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [24:0]        cfg_wdata = '0;

    synth_scoreboard sb = new();
    bit  tx_gaps = 1'b1;
    bit  rx_stalls = 1'b1;
    int  rx_hold = 0;
    int  rx_count = 0;

    polyphonic_wavetable_synth_core i_dut (.*);

    always #1 aclk = ~aclk;

    // Result side: random stalls, plus a long hold-off when the stimulus asks for one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_sample, m_keys_down, m_volume_halves);
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else if (rx_count > 0) begin
            rx_count--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (rx_stalls && $urandom_range(0, 9) < 3)
                rx_count = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 4)
                                                      : $urandom_range(20, 300);
        end
    end

    task automatic send(logic op, logic [7:0] code);
        int gap;
        s_valid <= 1'b1;
        s_op <= op;
        s_scan_code <= code;
        do @(posedge aclk); while (!s_ready);
        sb.note_request(op, code);
        gap = 0;
        if (tx_gaps && $urandom_range(0, 9) < 4)
            gap = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 60);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending_samples.size() != 0) @(posedge aclk);
        // A trailing scan code can still be in flight after the last result.
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_freqs(logic [24:0] values [8]);
        wait_drained();
        for (int i = 0; i < 8; i++) begin
            cfg_wen <= 1'b1;
            cfg_index <= 3'(i);
            cfg_wdata <= values[i];
            @(posedge aclk);
            sb.set_freq(i, values[i]);
        end
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic release_all();
        for (int v = 0; v < 8; v++) begin
            if (sb.keys[v]) begin
                send(OP_KEY, CODE_RELEASE);
                send(OP_KEY, NOTE_CODES[v]);
            end
        end
    endtask

    // Random ticks and mostly well-formed press/release/volume sequences, with a share of raw noise codes.
    task automatic random_items(int count);
        int r, v, n;
        n = 0;
        while (n < count) begin
            r = $urandom_range(0, 99);
            v = $urandom_range(0, 7);
            if (r < 32) begin
                send(OP_TICK, 8'($urandom_range(0, 255)));
            end else if (r < 55 && $countones(sb.keys) < 2) begin
                send(OP_KEY, NOTE_CODES[v]);
            end else if (r < 78) begin
                for (int k = 0; k < 8; k++)
                    if (sb.keys[(v + k) % 8]) begin
                        v = (v + k) % 8;
                        break;
                    end
                send(OP_KEY, CODE_RELEASE);
                send(OP_KEY, NOTE_CODES[v]);
                n++;
            end else if (r < 88) begin
                if ($urandom_range(0, 3) == 0) begin
                    send(OP_KEY, CODE_RELEASE);
                    n++;
                end
                send(OP_KEY, $urandom_range(0, 1) ? CODE_VOL_UP : CODE_VOL_DOWN);
            end else if (r < 92) begin
                send(OP_KEY, CODE_RELEASE);
            end else begin
                send(OP_KEY, 8'($urandom_range(0, 255)));
            end
            n++;
        end
    endtask

    initial begin
        logic [24:0] f [8];
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: every note, repeated and stale release marks, volume saturation.
        send(OP_TICK, 8'h00);
        for (int v = 0; v < 8; v++) send(OP_KEY, NOTE_CODES[v]);
        send(OP_TICK, 8'hFF);
        send(OP_KEY, CODE_RELEASE);
        send(OP_KEY, CODE_RELEASE);
        send(OP_KEY, NOTE_CODES[0]);
        send(OP_KEY, CODE_RELEASE);
        send(OP_KEY, 8'h00);
        send(OP_KEY, NOTE_CODES[1]);
        send(OP_KEY, CODE_RELEASE);
        send(OP_KEY, CODE_VOL_UP);
        send(OP_KEY, NOTE_CODES[2]);
        send(OP_TICK, 8'h5A);
        for (int i = 0; i < 22; i++) send(OP_KEY, CODE_VOL_UP);
        send(OP_TICK, 8'h00);
        for (int i = 0; i < 22; i++) send(OP_KEY, CODE_VOL_DOWN);
        send(OP_TICK, 8'h00);
        send(OP_KEY, CODE_VOL_UP);
        send(OP_KEY, CODE_VOL_UP);
        release_all();

        random_items(200);

        // Receiver holds off while ticks keep coming, so the input stalls.
        send(OP_KEY, NOTE_CODES[3]);
        rx_hold = 30000;
        for (int i = 0; i < 6; i++) send(OP_TICK, 8'h00);
        random_items(40);
        wait_drained();

        for (int i = 0; i < 8; i++) f[i] = (i % 2) ? FREQ_MAX : 25'd0;
        write_freqs(f);
        for (int v = 0; v < 8; v++) send(OP_KEY, NOTE_CODES[v]);
        send(OP_TICK, 8'h00);
        send(OP_TICK, 8'h00);
        release_all();
        random_items(150);

        for (int i = 0; i < 8; i++) f[i] = 25'($urandom());
        write_freqs(f);
        tx_gaps = 1'b0;
        rx_stalls = 1'b0;
        random_items(100);
        tx_gaps = 1'b1;
        rx_stalls = 1'b1;
        random_items(100);

        for (int i = 0; i < 8; i++) f[i] = 25'($urandom_range(0, 1 << 22));
        write_freqs(f);
        random_items(120);

        wait_drained();
        repeat (50) @(posedge aclk);
        if (sb.errors == 0) $display("SCOREBOARD CLEAN");
        else $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #400_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
